@@ src/mws_pkg.sv @@
// Shared types and constants for the masked 3x3 window sum block.
// No dependencies; imported by every module of the block except mws_ram.
package mws_pkg;

  localparam int MWS_MAX_WIDTH = 1024;
  localparam int KSIZE = 3;
  localparam int PIX_W = 8;
  localparam int SUM_W = 12;
  localparam int MASK_W = 9;
  localparam int FW_W = 11;
  localparam int FH_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MASK_W-1:0] MASK_RESET = 9'd341;
  localparam logic [FW_W-1:0] FW_RESET = 11'd450;
  localparam logic [FH_W-1:0] FH_RESET = 16'd450;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // Per-pixel markers produced by the position tracker.
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } win_flags_t;

endpackage

@@ src/mws_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old contents.
module mws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/mws_pos.sv @@
// Raster position tracker: column/row counters, window and end markers.
// Depends on mws_pkg.
module mws_pos #(
  parameter int MAX_WIDTH = mws_pkg::MWS_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         frame_start,
  input  logic [mws_pkg::FW_W-1:0]     frame_width,
  input  logic [mws_pkg::FH_W-1:0]     frame_height,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output mws_pkg::win_flags_t          flags
);
  import mws_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

  logic [CW-1:0]   column_count;
  logic [FH_W-1:0] row_count;
  logic [CW-1:0]   column_count_next;
  logic [FH_W-1:0] row_count_next;

  logic [FH_W-1:0] row;
  logic [EW-1:0]   fw_ext;
  logic [EW-1:0]   w_eff;
  logic [EW-1:0]   last_col;
  logic [EW-1:0]   col_ext;
  logic [FH_W-1:0] h_eff;
  logic [FH_W-1:0] last_row;

  always_comb begin
    col = frame_start ? '0 : column_count;
    row = frame_start ? '0 : row_count;

    // Clamp the size registers to the supported range.
    fw_ext = EW'(frame_width);
    if (fw_ext < EW'(KSIZE)) begin
      w_eff = EW'(KSIZE);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    h_eff = (frame_height < FH_W'(KSIZE)) ? FH_W'(KSIZE) : frame_height;
    last_col = w_eff - EW'(1);
    last_row = h_eff - FH_W'(1);
    col_ext  = EW'(col);

    flags.emit      = (row >= FH_W'(KSIZE - 1)) && (col_ext >= EW'(KSIZE - 1));
    flags.row_end   = (col_ext == last_col);
    flags.frame_end = (col_ext == last_col) && (row == last_row);

    // A shrunk size may leave the position past the end: wrap all the same.
    if (col_ext >= last_col) begin
      column_count_next = '0;
      row_count_next    = (row >= last_row) ? '0 : row + FH_W'(1);
    end else begin
      column_count_next = col + CW'(1);
      row_count_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

@@ src/mws_window.sv @@
// Window column registers, masked 3x3 adder and output register.
// Depends on mws_pkg.
module mws_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  mws_pkg::win_flags_t          flags,
  input  logic [mws_pkg::PIX_W-1:0]    px,
  input  logic [mws_pkg::PIX_W-1:0]    above,
  input  logic [mws_pkg::PIX_W-1:0]    top,
  input  logic [mws_pkg::MASK_W-1:0]   mask_bits,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [mws_pkg::SUM_W-1:0]    window_sum,
  output logic                         row_end,
  output logic                         frame_end
);
  import mws_pkg::*;

  // wr[c*3 + r]: column 0 is the oldest, row 0 the top
  logic [PIX_W-1:0] wr [6];
  logic [PIX_W-1:0] newcol [KSIZE];
  logic [PIX_W-1:0] tap [9];
  logic [SUM_W-1:0] sum;

  always_comb begin
    newcol[0] = top;
    newcol[1] = above;
    newcol[2] = px;
    for (int r = 0; r < KSIZE; r++) begin
      tap[r*3]     = wr[r];
      tap[r*3 + 1] = wr[3 + r];
      tap[r*3 + 2] = newcol[r];
    end
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      if (mask_bits[i]) begin
        sum = sum + SUM_W'(tap[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        wr[i] <= '0;
      end
    end else if (load) begin
      for (int r = 0; r < KSIZE; r++) begin
        wr[r]     <= wr[3 + r];
        wr[3 + r] <= newcol[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && flags.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && flags.emit) begin
      window_sum <= sum;
      row_end    <= flags.row_end;
      frame_end  <= flags.frame_end;
    end
  end

endmodule

@@ src/masked_window_sum_3x3.sv @@
// Masked 3x3 window sum over a raster pixel stream.
// Pixels enter on in_valid/in_ready with pixel_value and frame_start (first
// pixel of a frame). Each pixel at row >= 2 and column >= 2 completes a 3x3
// window; the sum of the pixels whose mask bit is set leaves on
// out_valid/out_ready with row_end and frame_end markers. A W x H frame gives
// (W-2) x (H-2) sums; other pixels produce no output transaction.
// Throughput: one pixel per cycle unless the output stalls. Each pixel costs
// one read and one write on each line-store RAM; the read is issued on
// acceptance and the write-back when the pixel leaves the s1 stage, with
// forwarding when two pixels in a row hit the same column.
// A sum passes through the s1 stage and the output register of mws_window.
// If the receiver stalls, one sum waits in the output register while the next
// pixel is still taken; in_ready drops only when that pixel also has a sum.
// Reset (synchronous) clears the position, the window columns and the output
// valid, and reloads the registers: mask 341, width 450, height 450. The line
// stores need no clearing. cfg_we writes register cfg_index at once; write
// only while the block is idle.
module masked_window_sum_3x3 #(
  parameter int MAX_WIDTH = mws_pkg::MWS_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mws_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mws_pkg::PIX_W-1:0]       pixel_value,
  input  logic                            frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mws_pkg::SUM_W-1:0]       window_sum,
  output logic                            row_end,
  output logic                            frame_end
);
  import mws_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [MASK_W-1:0] mask_bits;
  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;

  logic              in_accept;
  logic [CW-1:0]     pos_col;
  win_flags_t        pos_flags;

  logic              s1_valid;
  logic [CW-1:0]     s1_col;
  logic [PIX_W-1:0]  s1_px;
  win_flags_t        s1_flags;
  logic              s1_hit;
  logic [PIX_W-1:0]  s1_fwd_a;
  logic [PIX_W-1:0]  s1_fwd_b;
  logic              s1_fire;

  logic [PIX_W-1:0]  ram_a_q;
  logic [PIX_W-1:0]  ram_b_q;
  logic [PIX_W-1:0]  col_above;
  logic [PIX_W-1:0]  col_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_bits    <= MASK_RESET;
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASK:   mask_bits    <= cfg_data[MASK_W-1:0];
        REG_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default:    ;
      endcase
    end
  end

  assign s1_fire   = s1_valid && (!s1_flags.emit || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;
  assign in_accept = in_valid && in_ready;

  // RAM reads return old data; a write-back in the same cycle to the same
  // column is forwarded instead.
  assign col_above = s1_hit ? s1_fwd_a : ram_a_q;
  assign col_top   = s1_hit ? s1_fwd_b : ram_b_q;

  mws_pos #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .frame_start (frame_start),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .col         (pos_col),
    .flags       (pos_flags)
  );

  mws_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_a (
    .clk  (clk),
    .we   (s1_fire),
    .waddr(s1_col),
    .wdata(s1_px),
    .re   (in_accept),
    .raddr(pos_col),
    .rdata(ram_a_q)
  );

  mws_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_b (
    .clk  (clk),
    .we   (s1_fire),
    .waddr(s1_col),
    .wdata(col_above),
    .re   (in_accept),
    .raddr(pos_col),
    .rdata(ram_b_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col   <= pos_col;
      s1_px    <= pixel_value;
      s1_flags <= pos_flags;
      s1_hit   <= s1_fire && (s1_col == pos_col);
      s1_fwd_a <= s1_px;
      s1_fwd_b <= col_above;
    end
  end

  mws_window u_window (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_fire),
    .flags     (s1_flags),
    .px        (s1_px),
    .above     (col_above),
    .top       (col_top),
    .mask_bits (mask_bits),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .window_sum(window_sum),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

endmodule

@@ src/mws_checker.sv @@
// Port-level checks for masked_window_sum_3x3, attached by bind.
// Depends on mws_pkg.
module mws_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mws_pkg::SUM_W-1:0]    window_sum,
  input logic                         row_end,
  input logic                         frame_end
);
  import mws_pkg::*;

  // Output valid is cleared by reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // Input may only back up behind a stalled output transaction.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without output stall");

  // Last window of the frame is also last of its row.
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> row_end)
    else $error("frame_end without row_end");

  // Nine 8-bit taps at most.
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_sum <= SUM_W'(2295)))
    else $error("window_sum out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(window_sum)))
    else $error("stalled output changed");

endmodule

bind masked_window_sum_3x3 mws_checker u_mws_checker (.*);
